### hdl/angle_kalman_filter_assert.svh
// assertion macros for the angle kalman filter
`ifndef ANGLE_KALMAN_FILTER_ASSERT_SVH
`define ANGLE_KALMAN_FILTER_ASSERT_SVH

// consequent checked in the cycle after the antecedent
`define AKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("akf assertion failed");

// consequent checked in the same cycle as the antecedent
`define AKF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("akf assertion failed");

`endif

### hdl/akf_pkg.sv
package akf_pkg;

    localparam int DATA_W  = 25;
    localparam int WORD_W  = 32;
    localparam int CIDX_W  = 4;
    localparam int MUL_X_W = 41;
    localparam int MUL_Y_W = 33;
    localparam int MUL_A_W = 72;
    localparam int MUL_M_W = 48;
    localparam int MUL_R_W = 49;
    localparam int DEN_W   = 40;
    localparam int DIV_BITS = 62;
    localparam int DIV_CNT_W = 6;

    localparam logic [WORD_W-1:0] RESET_DT = 32'd335544;
    localparam logic [WORD_W-1:0] RESET_QA = 32'd16777;
    localparam logic [WORD_W-1:0] RESET_QG = 32'd83886;
    localparam logic [WORD_W-1:0] RESET_R  = 32'd8388608;
    localparam logic signed [WORD_W-1:0] ONE_Q30 = 32'sh4000_0000;

    typedef enum logic [CIDX_W-1:0] {
        CFG_DT = 4'd0,
        CFG_QA = 4'd1,
        CFG_QG = 4'd2,
        CFG_R  = 4'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE,
        ST_PAA,
        ST_PBB,
        ST_QG,
        ST_GAIN_A,
        ST_GAIN_B,
        ST_CAA,
        ST_CAB,
        ST_CBA,
        ST_CBB,
        ST_ANGLE,
        ST_BIAS,
        ST_OUT
    } akf_state_t;

    typedef enum logic [2:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_RND,
        MP_SGN
    } mul_phase_t;

    typedef enum logic [1:0] {
        DP_IDLE,
        DP_RUN,
        DP_FIN
    } div_phase_t;

    typedef struct packed {
        logic start;
        logic long_shift;
    } mul_req_t;

    function automatic logic signed [63:0] sx32(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic signed [63:0] sx49(input logic signed [MUL_R_W-1:0] v);
        return {{(64-MUL_R_W){v[MUL_R_W-1]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat25(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sh0000_0000_00FF_FFFF) begin
            r = 25'sh0FF_FFFF;
        end else if (v < -64'sh0000_0000_0100_0000) begin
            r = 25'sh100_0000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/akf_mul.sv
module akf_mul import akf_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mul_req_t                  req,
    input  logic signed [MUL_X_W-1:0] x,
    input  logic signed [MUL_Y_W-1:0] y,
    output logic                      done,
    output logic signed [MUL_R_W-1:0] res
);

    mul_phase_t phase_reg, phase_next;

    logic [MUL_X_W-2:0] mx_reg;
    logic [MUL_Y_W-2:0] my_reg;
    logic               neg_reg;
    logic               long_reg;
    logic [MUL_A_W-1:0] acc_reg;
    logic [MUL_M_W-1:0] mag_reg;

    logic [MUL_X_W-1:0] abs_x;
    logic [MUL_Y_W-1:0] abs_y;
    logic [MUL_A_W:0]   rnd_sum;

    assign abs_x = x[MUL_X_W-1] ? MUL_X_W'(-x) : MUL_X_W'(x);
    assign abs_y = y[MUL_Y_W-1] ? MUL_Y_W'(-y) : MUL_Y_W'(y);
    assign rnd_sum = long_reg ? ({1'b0, acc_reg} + ((MUL_A_W+1)'(1) << 29))
                              : ({1'b0, acc_reg} + ((MUL_A_W+1)'(1) << 23));

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            MP_IDLE: if (req.start) phase_next = MP_LO;
            MP_LO:   phase_next = MP_HI;
            MP_HI:   phase_next = MP_RND;
            MP_RND:  phase_next = MP_SGN;
            MP_SGN:  phase_next = MP_IDLE;
            default: phase_next = MP_IDLE;
        endcase
    end

    always_comb begin
        done = (phase_reg == MP_SGN);
        res  = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MP_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (phase_reg)
            MP_IDLE: begin
                mx_reg   <= abs_x[MUL_X_W-2:0];
                my_reg   <= abs_y[MUL_Y_W-2:0];
                neg_reg  <= x[MUL_X_W-1] ^ y[MUL_Y_W-1];
                long_reg <= req.long_shift;
            end
            MP_LO: acc_reg <= MUL_A_W'(mx_reg * my_reg[15:0]);
            MP_HI: acc_reg <= acc_reg + (MUL_A_W'(mx_reg * my_reg[31:16]) << 16);
            MP_RND: begin
                if (long_reg) begin
                    mag_reg <= MUL_M_W'(rnd_sum[MUL_A_W:30]);
                end else begin
                    mag_reg <= MUL_M_W'(rnd_sum[MUL_A_W:24]);
                end
            end
            MP_SGN: ;
            default: ;
        endcase
    end

endmodule

### hdl/akf_div.sv
module akf_div import akf_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [WORD_W-1:0] num,
    input  logic [DEN_W-1:0]         den,
    output logic                     done,
    output logic signed [WORD_W-1:0] quo
);

    div_phase_t phase_reg, phase_next;

    logic [DIV_BITS-1:0]  dvd_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;

    logic [WORD_W-1:0] abs_num;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign abs_num = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
    assign trial   = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign fits    = (trial >= {1'b0, den_reg});

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            DP_IDLE: if (start) phase_next = DP_RUN;
            DP_RUN:  if (cnt_reg == DIV_CNT_W'(DIV_BITS-1)) phase_next = DP_FIN;
            DP_FIN:  phase_next = DP_IDLE;
            default: phase_next = DP_IDLE;
        endcase
    end

    always_comb begin
        done = (phase_reg == DP_FIN);
        if (neg_reg) begin
            if (dvd_reg > DIV_BITS'(64'h8000_0000)) begin
                quo = 32'sh8000_0000;
            end else begin
                quo = -$signed(dvd_reg[WORD_W-1:0]);
            end
        end else begin
            if (dvd_reg > DIV_BITS'(64'h7FFF_FFFF)) begin
                quo = 32'sh7FFF_FFFF;
            end else begin
                quo = $signed(dvd_reg[WORD_W-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= DP_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (phase_reg)
            DP_IDLE: begin
                dvd_reg <= {abs_num, 30'd0};
                rem_reg <= '0;
                den_reg <= den;
                cnt_reg <= '0;
                neg_reg <= num[WORD_W-1];
            end
            DP_RUN: begin
                rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                dvd_reg <= {dvd_reg[DIV_BITS-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
            end
            DP_FIN: ;
            default: ;
        endcase
    end

endmodule

### hdl/angle_kalman_filter.sv
// Two-state Kalman filter for tilt angle and gyro bias. Each sample (accelerometer
// angle and gyro rate, Q8.16) gives one result: corrected angle, rate minus bias and
// bias, all saturated Q8.16. Configuration (dt and the three noise variances, Q8.24)
// is written on the cfg port; the user must write it only while the filter is idle,
// which the block itself does not enforce, and indexes above three are ignored.
// Each sample runs ten products on a shared 40x16 multiplier and two gains on a
// shared radix-2 divider. When the innovation variance is not positive the divider
// is skipped. A new sample is taken only when the filter is idle; a finished result
// may still wait in the output register.
module angle_kalman_filter import akf_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_measured_angle,
    input  logic signed [DATA_W-1:0] s_measured_rate,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_angle_estimate,
    output logic signed [DATA_W-1:0] m_rate_estimate,
    output logic signed [DATA_W-1:0] m_bias_estimate,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [WORD_W-1:0]        cfg_data
);

    akf_state_t state_reg, state_next;

    logic [WORD_W-1:0] dt_reg, qa_reg, qg_reg, r_reg;

    logic signed [WORD_W-1:0] angle_reg, bias_reg;
    logic signed [WORD_W-1:0] c00_reg, c01_reg, c10_reg, c11_reg;
    logic signed [WORD_W-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [WORD_W-1:0] k0_reg, k1_reg, err_reg;
    logic signed [DATA_W-1:0] meas_reg, gyro_reg;
    logic                     started_reg;
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] out_angle_reg, out_rate_reg, out_bias_reg;

    mul_req_t                  mul_req;
    logic signed [MUL_X_W-1:0] mul_x;
    logic signed [MUL_Y_W-1:0] mul_y;
    logic                      mul_done;
    logic signed [MUL_R_W-1:0] mul_res;
    logic signed [63:0]        prod;

    logic                     div_start;
    logic signed [WORD_W-1:0] div_num;
    logic                     div_done;
    logic signed [WORD_W-1:0] div_quo;

    logic signed [DEN_W-1:0] innov_var;
    logic                    innov_pos;
    logic                    is_mul, is_div, unit_done;
    logic                    s_xfer;

    assign innov_var = $signed({2'b00, r_reg, 6'b0}) + {{(DEN_W-WORD_W){p00_reg[31]}}, p00_reg};
    assign innov_pos = !innov_var[DEN_W-1] && (innov_var != '0);
    assign prod      = sx49(mul_res);
    assign s_xfer    = s_valid && s_ready;
    assign unit_done = mul_done || div_done;

    assign s_ready          = (state_reg == ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_angle_estimate = out_angle_reg;
    assign m_rate_estimate  = out_rate_reg;
    assign m_bias_estimate  = out_bias_reg;

    akf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .x       (mul_x),
        .y       (mul_y),
        .done    (mul_done),
        .res     (mul_res)
    );

    akf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (innov_var),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_xfer) state_next = ST_RATE;
            ST_RATE:   if (unit_done) state_next = ST_PAA;
            ST_PAA:    if (unit_done) state_next = ST_PBB;
            ST_PBB:    if (unit_done) state_next = ST_QG;
            ST_QG:     if (unit_done) state_next = innov_pos ? ST_GAIN_A : ST_CAA;
            ST_GAIN_A: if (unit_done) state_next = ST_GAIN_B;
            ST_GAIN_B: if (unit_done) state_next = ST_CAA;
            ST_CAA:    if (unit_done) state_next = ST_CAB;
            ST_CAB:    if (unit_done) state_next = ST_CBA;
            ST_CBA:    if (unit_done) state_next = ST_CBB;
            ST_CBB:    if (unit_done) state_next = ST_ANGLE;
            ST_ANGLE:  if (unit_done) state_next = ST_BIAS;
            ST_BIAS:   if (unit_done) state_next = ST_OUT;
            ST_OUT:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        is_mul = 1'b0;
        is_div = 1'b0;
        mul_x  = '0;
        mul_y  = $signed({1'b0, dt_reg});
        mul_req.long_shift = 1'b0;
        div_num = p00_reg;
        unique case (state_reg)
            ST_RATE: begin
                is_mul = 1'b1;
                mul_x  = {{(MUL_X_W-DATA_W){gyro_reg[DATA_W-1]}}, gyro_reg}
                       - {{(MUL_X_W-WORD_W){bias_reg[31]}}, bias_reg};
            end
            ST_PAA: begin
                is_mul = 1'b1;
                mul_x  = $signed({3'b000, qa_reg, 6'b0})
                       - {{(MUL_X_W-WORD_W){c01_reg[31]}}, c01_reg}
                       - {{(MUL_X_W-WORD_W){c10_reg[31]}}, c10_reg};
            end
            ST_PBB: begin
                is_mul = 1'b1;
                mul_x  = {{(MUL_X_W-WORD_W){c11_reg[31]}}, c11_reg};
            end
            ST_QG: begin
                is_mul = 1'b1;
                mul_x  = $signed({3'b000, qg_reg, 6'b0});
            end
            ST_GAIN_A: is_div = 1'b1;
            ST_GAIN_B: begin
                is_div  = 1'b1;
                div_num = p10_reg;
            end
            ST_CAA, ST_CAB, ST_CBA, ST_CBB, ST_ANGLE, ST_BIAS: begin
                is_mul = 1'b1;
                mul_req.long_shift = 1'b1;
                if (state_reg == ST_CAA || state_reg == ST_CBA) begin
                    mul_x = {{(MUL_X_W-WORD_W){p00_reg[31]}}, p00_reg};
                end else if (state_reg == ST_CAB || state_reg == ST_CBB) begin
                    mul_x = {{(MUL_X_W-WORD_W){p01_reg[31]}}, p01_reg};
                end else begin
                    mul_x = {{(MUL_X_W-WORD_W){err_reg[31]}}, err_reg};
                end
                if (state_reg == ST_CAA || state_reg == ST_CAB || state_reg == ST_ANGLE) begin
                    mul_y = {k0_reg[31], k0_reg};
                end else begin
                    mul_y = {k1_reg[31], k1_reg};
                end
            end
            default: ;
        endcase
        mul_req.start = is_mul && !started_reg;
        div_start     = is_div && !started_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            dt_reg      <= RESET_DT;
            qa_reg      <= RESET_QA;
            qg_reg      <= RESET_QG;
            r_reg       <= RESET_R;
            angle_reg   <= '0;
            bias_reg    <= '0;
            c00_reg     <= ONE_Q30;
            c01_reg     <= '0;
            c10_reg     <= '0;
            c11_reg     <= ONE_Q30;
        end else begin
            state_reg <= state_next;
            if (unit_done) begin
                started_reg <= 1'b0;
            end else if (is_mul || is_div) begin
                started_reg <= 1'b1;
            end

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_DT:  dt_reg <= cfg_data;
                    CFG_QA:  qa_reg <= cfg_data;
                    CFG_QG:  qg_reg <= cfg_data;
                    CFG_R:   r_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (unit_done) begin
                unique case (state_reg)
                    ST_RATE:  angle_reg <= sat32(sx32(angle_reg) + prod);
                    ST_CAA:   c00_reg   <= sat32(sx32(p00_reg) - prod);
                    ST_CAB:   c01_reg   <= sat32(sx32(p01_reg) - prod);
                    ST_CBA:   c10_reg   <= sat32(sx32(p10_reg) - prod);
                    ST_CBB:   c11_reg   <= sat32(sx32(p11_reg) - prod);
                    ST_ANGLE: angle_reg <= sat32(sx32(angle_reg) + prod);
                    ST_BIAS:  bias_reg  <= sat32(sx32(bias_reg) + prod);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            meas_reg <= s_measured_angle;
            gyro_reg <= s_measured_rate;
            k0_reg   <= '0;
            k1_reg   <= '0;
        end
        if (unit_done) begin
            unique case (state_reg)
                ST_PAA: begin
                    p00_reg <= sat32(sx32(c00_reg) + prod);
                    err_reg <= sat32({{(64-DATA_W){meas_reg[DATA_W-1]}}, meas_reg}
                                     - sx32(angle_reg));
                end
                ST_PBB: begin
                    p01_reg <= sat32(sx32(c01_reg) - prod);
                    p10_reg <= sat32(sx32(c10_reg) - prod);
                end
                ST_QG:     p11_reg <= sat32(sx32(c11_reg) + prod);
                ST_GAIN_A: k0_reg  <= div_quo;
                ST_GAIN_B: k1_reg  <= div_quo;
                default: ;
            endcase
        end
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            out_angle_reg <= sat25(sx32(angle_reg));
            out_rate_reg  <= sat25({{(64-DATA_W){gyro_reg[DATA_W-1]}}, gyro_reg}
                                   - sx32(bias_reg));
            out_bias_reg  <= sat25(sx32(bias_reg));
        end
    end

endmodule

### hdl/akf_checker.sv
`include "angle_kalman_filter_assert.svh"

module akf_assert_checker import akf_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic signed [DATA_W-1:0] s_measured_angle,
    input logic signed [DATA_W-1:0] s_measured_rate,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [DATA_W-1:0] m_angle_estimate,
    input logic signed [DATA_W-1:0] m_rate_estimate,
    input logic signed [DATA_W-1:0] m_bias_estimate,
    input logic                     cfg_valid,
    input logic                     cfg_ready,
    input logic [CIDX_W-1:0]        cfg_index,
    input logic [WORD_W-1:0]        cfg_data
);

    // a stalled result stays put
    `AKF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_angle_estimate) && $stable(m_rate_estimate) && $stable(m_bias_estimate))

    // busy right after a sample transfer
    `AKF_ASSERT_NEXT(a_busy_after_xfer, aclk, aresetn, s_valid && s_ready, !s_ready)

    // out of reset idle with no result pending
    `AKF_ASSERT_SAME(a_reset_idle, aclk, aresetn, $rose(aresetn), s_ready && !m_valid)

endmodule

bind angle_kalman_filter akf_assert_checker u_akf_checker (.*);
